@@ hw/rtl/cas_pkg.sv @@
// Package for the CIGAR span unit: payload structs, the job record passed
// from the front to the back, and shared constants. No dependencies.
`timescale 1ns / 1ps

package cas_pkg;

	// Fraction bits of the divergence fixed-point result.
	localparam int FRAC_BITS = 20;
	// Width of the divergence result; values above its range saturate.
	localparam int DIV_OUT_W = 24;
	// Depth of the job queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// CIGAR operation codes.
	localparam logic [3:0] OP_MATCH    = 4'd0;
	localparam logic [3:0] OP_INS      = 4'd1;
	localparam logic [3:0] OP_DEL      = 4'd2;
	localparam logic [3:0] OP_SKIP     = 4'd3;
	localparam logic [3:0] OP_SOFTCLIP = 4'd4;
	localparam logic [3:0] OP_HARDCLIP = 4'd5;
	localparam logic [3:0] OP_EQUAL    = 4'd7;
	localparam logic [3:0] OP_DIFF     = 4'd8;

	typedef struct packed {
		logic [3:0]  cigar_op;
		logic [27:0] cigar_len;
		logic        last_of_read;
		logic [30:0] read_pos;
		logic        reverse_strand;
		logic [30:0] seq_len;
		logic        drop_read;
		logic        nm_present;
		logic [30:0] nm_value;
	} in_item_t;

	typedef struct packed {
		logic [31:0]           ref_end;
		logic signed [31:0]    query_begin;
		logic signed [31:0]    query_end;
		logic [DIV_OUT_W-1:0]  divergence;
		logic                  divergence_invalid;
	} out_item_t;

	// One finished read, as handed from the front to the back.
	typedef struct packed {
		logic [31:0] ref_span;
		logic [31:0] query_len;
		logic [27:0] clip;
		logic [31:0] edits;
		logic [31:0] aligned;
		logic [30:0] read_pos;
		logic        reverse_strand;
		logic [30:0] seq_len;
		logic        extended;
	} job_t;

	// Status of the back, for checks at the top level.
	typedef struct packed {
		logic busy;
		logic result_valid;
	} back_status_t;

endpackage

@@ hw/rtl/cigar_alignment_span.sv @@
// Top level of the CIGAR span unit: joins front, job queue and back.
// Depends on cas_pkg, cas_front, cas_queue and cas_back.
//
//  channel   handshake          payload
//  input     push / full        in_item  (in_item_t)
//  result    empty / pop        result   (out_item_t)
//  config    cfg_we             cfg_wdata (extended_mode)
//
// The front takes one CIGAR word per cycle while the job queue has room.
// Each kept read takes the back through its load and prepare states and,
// in extended mode with a nonzero aligned length, the bit-serial divider;
// the result then waits in the back until popped. Reads queue up to four
// deep meanwhile. Reset clears the accumulators, queue and sequencer at once.
`timescale 1ns / 1ps

module cigar_alignment_span (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  cas_pkg::in_item_t   in_item,
	output logic                empty,
	input  logic                pop,
	output cas_pkg::out_item_t  result,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import cas_pkg::*;

	logic         extended_mode_q;
	logic         item_valid;
	logic         job_push;
	job_t         job_in;
	job_t         job_out;
	logic         q_pop;
	logic         q_full;
	logic         q_empty;
	back_status_t back_status;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extended_mode_q <= 1'b0;
		end else if (cfg_we) begin
			extended_mode_q <= cfg_wdata;
		end
	end

	// An input transfer happens while the queue has room.
	always_comb begin
		full = q_full;
		item_valid = push && !q_full;
	end

	cas_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item          (in_item),
		.extended_mode (extended_mode_q),
		.job_push      (job_push),
		.job           (job_in)
	);

	cas_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_in),
		.rd_en   (q_pop),
		.rd_data (job_out),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	cas_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (job_out),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result),
		.status  (back_status)
	);

	// An invalid divergence always reads as zero.
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.divergence_invalid) |-> (result.divergence == '0))
		else $error("divergence not zero while flagged invalid");

	// A result only appears after the back has worked on a job.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(back_status.busy))
		else $error("result shown without a job in the back");

	// The result port and the back status agree.
	a_status_match: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.result_valid == !empty)
		else $error("result valid does not match empty");

	// The back only takes a job from a nonempty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job taken from an empty queue");

endmodule

@@ hw/rtl/cas_front.sv @@
// Front of the CIGAR span unit: accumulates the per-read sums one CIGAR word
// per cycle while item_valid is high and emits a job record on each kept read. Uses cas_pkg.
`timescale 1ns / 1ps

module cas_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  cas_pkg::in_item_t item,
	input  logic              extended_mode,
	output logic              job_push,
	output cas_pkg::job_t     job
);
	import cas_pkg::*;

	logic [31:0] ref_span_q;
	logic [31:0] query_len_q;
	logic [31:0] indel_q;
	logic [31:0] aligned_q;
	logic [27:0] clip_q;
	logic        start_q;

	logic        m_like;
	logic        is_clip;
	logic [31:0] ref_span_nx;
	logic [31:0] query_len_nx;
	logic [31:0] indel_nx;
	logic [31:0] aligned_nx;
	logic [27:0] clip_nx;

	// Add a 28-bit length to a 32-bit sum, saturating at all ones.
	function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [27:0] len);
		logic [32:0] s;
		s = {1'b0, acc} + {5'b0, len};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Classify the operation and form the sums including this word.
	always_comb begin
		m_like = (item.cigar_op == OP_MATCH) || (item.cigar_op == OP_EQUAL) ||
			(item.cigar_op == OP_DIFF);
		is_clip = (item.cigar_op == OP_SOFTCLIP) || (item.cigar_op == OP_HARDCLIP);
		ref_span_nx = (m_like || item.cigar_op == OP_DEL || item.cigar_op == OP_SKIP) ?
			sat_add(ref_span_q, item.cigar_len) : ref_span_q;
		query_len_nx = (m_like || item.cigar_op == OP_INS) ?
			sat_add(query_len_q, item.cigar_len) : query_len_q;
		indel_nx = (item.cigar_op == OP_INS || item.cigar_op == OP_DEL) ?
			sat_add(indel_q, item.cigar_len) : indel_q;
		aligned_nx = (m_like || item.cigar_op == OP_INS || item.cigar_op == OP_DEL) ?
			sat_add(aligned_q, item.cigar_len) : aligned_q;
		if (start_q) begin
			clip_nx = is_clip ? item.cigar_len : 28'd0;
		end else begin
			clip_nx = clip_q;
		end
	end

	// Job record for the read that ends with this word.
	always_comb begin
		job_push = item_valid && item.last_of_read && !item.drop_read;
		job.ref_span = ref_span_nx;
		job.query_len = query_len_nx;
		job.clip = clip_nx;
		job.edits = item.nm_present ? {1'b0, item.nm_value} : indel_nx;
		job.aligned = aligned_nx;
		job.read_pos = item.read_pos;
		job.reverse_strand = item.reverse_strand;
		job.seq_len = item.seq_len;
		job.extended = extended_mode;
	end

	// Accumulators; the last word of a read clears them for the next read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_span_q <= '0;
			query_len_q <= '0;
			indel_q <= '0;
			aligned_q <= '0;
			clip_q <= '0;
			start_q <= 1'b1;
		end else if (item_valid) begin
			if (item.last_of_read) begin
				ref_span_q <= '0;
				query_len_q <= '0;
				indel_q <= '0;
				aligned_q <= '0;
				clip_q <= '0;
				start_q <= 1'b1;
			end else begin
				ref_span_q <= ref_span_nx;
				query_len_q <= query_len_nx;
				indel_q <= indel_nx;
				aligned_q <= aligned_nx;
				clip_q <= clip_nx;
				start_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/cas_queue.sv @@
// Short job queue between the front and the back of the CIGAR span unit.
// Holds job_t records from cas_pkg in a small register array.
`timescale 1ns / 1ps

module cas_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  cas_pkg::job_t wr_data,
	input  logic          rd_en,
	output cas_pkg::job_t rd_data,
	output logic          q_full,
	output logic          q_empty
);
	import cas_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	always_comb begin
		q_full = (count_q == CNT_W'(QUEUE_DEPTH));
		q_empty = (count_q == '0);
		do_wr = wr_en && !q_full;
		do_rd = rd_en && !q_empty;
		rd_data = mem_q[rd_ptr_q];
	end

	// Storage for queued jobs.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/cas_back.sv @@
// Back of the CIGAR span unit: takes one job at a time from the queue,
// forms the reference end and query coordinates and runs a bit-serial
// divider for the divergence. Uses cas_pkg.
`timescale 1ns / 1ps

module cas_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  cas_pkg::job_t         q_data,
	output logic                  q_pop,
	input  logic                  pop,
	output logic                  empty,
	output cas_pkg::out_item_t    result,
	output cas_pkg::back_status_t status
);
	import cas_pkg::*;

	localparam int DIV_W = 32 + FRAC_BITS;
	localparam int CNT_W = $clog2(DIV_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]           state_q;
	job_t                 job_q;
	logic [32:0]          qsum_q;
	logic [31:0]          ref_end_q;
	logic signed [31:0]   qbeg_q;
	logic signed [31:0]   qend_q;
	logic [31:0]          rem_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [DIV_OUT_W-1:0] quo_q;
	logic                 ovf_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_OUT_W-1:0] divg_q;
	logic                 inv_q;

	logic [32:0]          ref_sum;
	logic [32:0]          trial;
	logic                 ge;
	logic [32:0]          diff;
	logic [31:0]          rem_nx;
	logic [DIV_OUT_W-1:0] quo_nx;
	logic                 ovf_nx;
	logic signed [34:0]   rev_beg;
	logic signed [34:0]   rev_end;

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] clamp_s32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -35'sd2147483648) begin
			return 32'sh8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

	// Reference end and reverse-strand coordinates.
	always_comb begin
		ref_sum = {2'b0, q_data.read_pos} + {1'b0, q_data.ref_span};
		rev_beg = $signed({4'b0, job_q.seq_len}) - $signed({2'b0, qsum_q});
		rev_end = $signed({4'b0, job_q.seq_len}) - $signed({7'b0, job_q.clip});
	end

	// One restoring division step: a quotient bit from the top of the dividend.
	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		ge = (trial >= {1'b0, job_q.aligned});
		diff = trial - {1'b0, job_q.aligned};
		rem_nx = ge ? diff[31:0] : trial[31:0];
		quo_nx = {quo_q[DIV_OUT_W-2:0], ge};
		ovf_nx = ovf_q || quo_q[DIV_OUT_W-1];
	end

	always_comb begin
		q_pop = (state_q == ST_IDLE) && !q_empty;
		empty = (state_q != ST_DONE);
		result.ref_end = ref_end_q;
		result.query_begin = qbeg_q;
		result.query_end = qend_q;
		result.divergence = divg_q;
		result.divergence_invalid = inv_q;
		status.busy = (state_q != ST_IDLE);
		status.result_valid = (state_q == ST_DONE);
	end

	// Sequencer: load, coordinates, divide (extended mode, nonzero aligned length), hold the result until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= (job_q.extended && job_q.aligned != '0) ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (pop) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				job_q <= q_data;
				qsum_q <= {5'b0, q_data.clip} + {1'b0, q_data.query_len};
				ref_end_q <= ref_sum[32] ? 32'hFFFF_FFFF : ref_sum[31:0];
			end
			ST_PREP: begin
				if (!job_q.extended) begin
					qbeg_q <= '0;
					qend_q <= '0;
				end else if (job_q.reverse_strand) begin
					qbeg_q <= clamp_s32(rev_beg);
					qend_q <= clamp_s32(rev_end);
				end else begin
					qbeg_q <= $signed({4'b0, job_q.clip});
					qend_q <= clamp_s32($signed({2'b0, qsum_q}));
				end
				divg_q <= '0;
				inv_q <= job_q.extended && (job_q.aligned == '0);
				rem_q <= '0;
				dvd_q <= {job_q.edits, {FRAC_BITS{1'b0}}};
				quo_q <= '0;
				ovf_q <= 1'b0;
				cnt_q <= CNT_W'(DIV_W - 1);
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
				quo_q <= quo_nx;
				ovf_q <= ovf_nx;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					divg_q <= ovf_nx ? {DIV_OUT_W{1'b1}} : quo_nx;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule
